// File: sv/psr_pkg.sv
// Shared constants, coefficient tables and the coefficient fetch helper of the sinc resampler.
package psr_pkg;

	localparam int HALF_TAPS_DEF       = 8;
	localparam int PHASE_FRAC_BITS_DEF = 30;
	localparam int ROW_INDEX_BITS_DEF  = 4;
	localparam int MAX_RESULTS         = 8;
	localparam int ROM_SIZE            = 129;
	localparam int ROM_AW              = 8;
	localparam int CFG_IDX_W           = 3;
	localparam int CFG_DATA_W          = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_TAB  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_L     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_R     = 3'd4;

	localparam logic [31:0] PHASE_INC_RST = 32'h4000_0000;
	localparam logic [15:0] VOL_RST       = 16'sd4096;

	typedef struct packed {
		logic [31:0] phase_inc;
		logic        down_tab;
		logic        stereo;
		logic [15:0] vol_l;
		logic [15:0] vol_r;
	} cfg_t;

	// One queued job: one output frame to compute from a history snapshot.
	typedef struct packed {
		logic [31:0] phase;
		logic        last;
	} job_t;

	localparam logic [31:0] ROM_UP [ROM_SIZE] = '{
	 32'h7fffffff,32'h7f15d078,32'h7c5e0da6,32'h77ecd867,32'h71e2e251,32'h6a6c304a,32'h61be7269,32'h58170412,
	 32'h4db8ab05,32'h42e92ea6,32'h37eee214,32'h2d0e3bb1,32'h22879366,32'h18951e95,32'h0f693d0d,32'h072d2621,
	 32'h00000000,32'hf9f66655,32'hf51a5fd7,32'hf16bbd84,32'heee0d9ac,32'hed67a922,32'hece70de6,32'hed405897,
	 32'hee50e505,32'heff3be30,32'hf203370f,32'hf45a6741,32'hf6d67d53,32'hf957db66,32'hfbc2f647,32'hfe00f2b9,
	 32'h00000000,32'h01b37218,32'h0313a0c6,32'h041d930d,32'h04d28057,32'h053731b0,32'h05534dff,32'h05309bfd,
	 32'h04da440d,32'h045c1aee,32'h03c1fcdd,32'h03173ef5,32'h02663ae8,32'h01b7f736,32'h0113ec79,32'h007fe6a9,
	 32'h00000000,32'hff96b229,32'hff44f99f,32'hff0a86be,32'hfee5f803,32'hfed518fd,32'hfed521fd,32'hfee2f4fd,
	 32'hfefb54f8,32'hff1b159b,32'hff3f4203,32'hff6539e0,32'hff8ac502,32'hffae1ddd,32'hffcdf3f9,32'hffe96798,
	 32'h00000000,32'h00119de6,32'h001e6b7e,32'h0026cb7a,32'h002b4830,32'h002c83d6,32'h002b2a82,32'h0027e67a,
	 32'h002356f9,32'h001e098e,32'h001875e4,32'h0012fbbe,32'h000de2d1,32'h00095c10,32'h00058414,32'h00026636,
	 32'h00000000,32'hfffe44a9,32'hfffd206d,32'hfffc7b7f,32'hfffc3c8f,32'hfffc4ac2,32'hfffc8f2b,32'hfffcf5c4,
	 32'hfffd6df3,32'hfffdeab2,32'hfffe6275,32'hfffececf,32'hffff2c07,32'hffff788c,32'hffffb471,32'hffffe0f2,
	 32'h00000000,32'h000013e6,32'h00001f03,32'h00002396,32'h00002399,32'h000020b6,32'h00001c3c,32'h00001722,
	 32'h00001216,32'h00000d81,32'h0000099c,32'h0000067c,32'h00000419,32'h0000025f,32'h00000131,32'h00000070,
	 32'h00000000,32'hffffffc7,32'hffffffb3,32'hffffffb3,32'hffffffbe,32'hffffffcd,32'hffffffdb,32'hffffffe7,
	 32'hfffffff0,32'hfffffff7,32'hfffffffb,32'hfffffffe,32'hffffffff,32'h00000000,32'h00000000,32'h00000000,
	 32'h00000000
	};

	localparam logic [31:0] ROM_DOWN [ROM_SIZE] = '{
	 32'h7fffffff,32'h7f55e46d,32'h7d5b4c60,32'h7a1b4b98,32'h75a7fb14,32'h7019f0bd,32'h698f875a,32'h622bfd59,
	 32'h5a167256,32'h5178cc54,32'h487e8e6c,32'h3f53aae8,32'h36235ad4,32'h2d17047b,32'h245539ab,32'h1c00d540,
	 32'h14383e57,32'h0d14d5ca,32'h06aa910b,32'h0107c38b,32'hfc351654,32'hf835abae,32'hf5076b45,32'hf2a37202,
	 32'hf0fe9faa,32'hf00a3bbd,32'hefb4aa81,32'hefea2b05,32'hf0959716,32'hf1a11e83,32'hf2f6f7a0,32'hf481fff4,
	 32'hf62e48ce,32'hf7e98ca5,32'hf9a38b4c,32'hfb4e4bfa,32'hfcde456f,32'hfe4a6d30,32'hff8c2fdf,32'h009f5555,
	 32'h0181d393,32'h0233940f,32'h02b62f06,32'h030ca07d,32'h033afa62,32'h03461725,32'h03334f83,32'h030835fa,
	 32'h02ca59cc,32'h027f12d1,32'h022b570d,32'h01d39a49,32'h017bb78f,32'h0126e414,32'h00d7aaaf,32'h008feec7,
	 32'h0050f584,32'h001b73e3,32'hffefa063,32'hffcd46ed,32'hffb3ddcd,32'hffa29aaa,32'hff988691,32'hff949066,
	 32'hff959d24,32'hff9a959e,32'hffa27195,32'hffac4011,32'hffb72d2b,32'hffc28569,32'hffcdb706,32'hffd85171,
	 32'hffe20364,32'hffea97e9,32'hfff1f2b2,32'hfff80c06,32'hfffcec92,32'h0000a955,32'h00035fd8,32'h000532cf,
	 32'h00064735,32'h0006c1f9,32'h0006c62d,32'h000673ba,32'h0005e68f,32'h00053630,32'h000475a3,32'h0003b397,
	 32'h0002fac1,32'h00025257,32'h0001be9e,32'h0001417a,32'h0000dafd,32'h000089eb,32'h00004c28,32'h00001f1d,
	 32'h00000000,32'hffffec10,32'hffffe0be,32'hffffdbc5,32'hffffdb39,32'hffffdd8b,32'hffffe182,32'hffffe638,
	 32'hffffeb0a,32'hffffef8f,32'hfffff38b,32'hfffff6e3,32'hfffff993,32'hfffffba6,32'hfffffd30,32'hfffffe4a,
	 32'hffffff09,32'hffffff85,32'hffffffd1,32'hfffffffb,32'h0000000f,32'h00000016,32'h00000015,32'h00000012,
	 32'h0000000d,32'h00000009,32'h00000006,32'h00000003,32'h00000002,32'h00000001,32'h00000000,32'h00000000,
	 32'h00000000
	};

	// Coefficient fetch; anything past the end of the table reads zero.
	function automatic logic [31:0] rom_read(input logic down, input logic [ROM_AW-1:0] idx);
		logic [31:0] v;
		v = '0;
		if (32'(idx) < ROM_SIZE) begin
			v = down ? ROM_DOWN[idx] : ROM_UP[idx];
		end
		return v;
	endfunction

endpackage

// File: sv/psr_front.sv
// Front end: history line, phase bookkeeping, job issue into the queue.
module psr_front #(
	parameter int HIST_DEPTH      = 16,
	parameter int PHASE_FRAC_BITS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         in_frame,
	input  logic [31:0]         phase_inc,
	input  logic                hist_free,
	output logic [31:0]         hist_q [HIST_DEPTH],
	output logic                job_valid,
	input  logic                job_ready,
	output psr_pkg::job_t       job
);

	localparam int CNT_W = $clog2(psr_pkg::MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [31:0]        phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               in_fire;
	logic               below_one;
	logic [31:0]        phase_adj;
	logic               more;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE) && hist_free;
	assign phase_adj = (phase_q >> PHASE_FRAC_BITS) != '0
		? phase_q - (32'd1 << PHASE_FRAC_BITS) : phase_q;
	assign below_one = (phase_q >> PHASE_FRAC_BITS) == '0;
	// after issuing this job: is another one due?
	assign more = (((phase_q + phase_inc) >> PHASE_FRAC_BITS) == '0)
		&& (cnt_q < CNT_W'(psr_pkg::MAX_RESULTS - 1));

	assign job_valid  = (state_q == ST_ISSUE);
	assign job.phase  = phase_q;
	assign job.last   = !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						for (int i = 0; i < HIST_DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
						hist_q[HIST_DEPTH-1] <= in_frame;
						phase_q <= phase_adj;
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// phase settled; decide whether this frame makes output
					state_q <= below_one ? ST_ISSUE : ST_IDLE;
				end
				ST_ISSUE: begin
					if (job_ready) begin
						phase_q <= phase_q + phase_inc;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= more ? ST_ISSUE : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(psr_pkg::MAX_RESULTS))
		else $error("job count beyond limit");
	a_issue_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> below_one)
		else $error("job issued with phase at or above one");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("frame accepted while front busy");
`endif

endmodule

// File: sv/psr_back.sv
// Back end: a multiply-accumulate product, shared by both channels, walks the taps of each queued job.
module psr_back #(
	parameter int HALF_TAPS       = 8,
	parameter int PHASE_FRAC_BITS = 30,
	parameter int ROW_INDEX_BITS  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psr_pkg::cfg_t       cfg,
	input  logic [31:0]         hist [2*HALF_TAPS],
	input  logic                job_valid,
	output logic                job_ready,
	input  psr_pkg::job_t       job,
	output logic                busy,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [31:0]         res_l,
	output logic [31:0]         res_r,
	output logic                res_last
);

	localparam int ROW_SHIFT  = PHASE_FRAC_BITS - ROW_INDEX_BITS;
	localparam int LERP_SHIFT = ROW_SHIFT - 15;
	localparam int ROW_MAX    = (1 << ROW_INDEX_BITS) - 1;
	localparam int TAP_W      = $clog2(HALF_TAPS);
	localparam int HD_W       = $clog2(2 * HALF_TAPS);
	localparam int ROM_AW_L   = psr_pkg::ROM_AW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF,
		ST_MACL,
		ST_MACR,
		ST_VOL,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [ROW_INDEX_BITS-1:0] ip_q, in_q;
	logic [14:0]               lp_q, ln_q;
	logic                      last_q;
	logic [TAP_W-1:0]          tap_q;
	logic                      side_q;   // 0 positive side, 1 negative side
	logic [31:0]               coef_q;
	logic [31:0]               accl_q, accr_q;
	logic [31:0]               outl_q, outr_q;
	logic                      outv_q, outlast_q;

	// coefficient for current tap and side
	logic [ROW_INDEX_BITS-1:0] row;
	logic [14:0]               lerp;
	logic [ROM_AW_L-1:0]       idx;
	logic [31:0]               c0, c1, d;
	logic signed [15:0]        dtop;
	logic signed [31:0]        lmul;
	logic [31:0]               coef_full;
	logic [HD_W-1:0]           hidx;
	logic [31:0]               frame;
	logic signed [15:0]        cp;
	logic signed [15:0]        samp;
	logic signed [31:0]        prod;
	logic [31:0]               phase_n;
	logic                      zero_frac;
	logic signed [31:0]        scl, scr;

	assign row  = side_q ? in_q : ip_q;
	assign lerp = side_q ? ln_q : lp_q;
	assign idx  = ROM_AW_L'({tap_q, row});
	assign c0   = psr_pkg::rom_read(cfg.down_tab, idx);
	assign c1   = psr_pkg::rom_read(cfg.down_tab, idx + 1'b1);
	assign d    = (c1 - c0) << 1;
	assign dtop = d[31:16];
	assign lmul = $signed({1'b0, lerp}) * dtop;
	assign coef_full = c0 + 32'(lmul);

	assign hidx  = side_q ? HD_W'(HALF_TAPS + 32'(tap_q)) : HD_W'(HALF_TAPS - 1 - 32'(tap_q));
	assign frame = hist[hidx];
	assign cp    = coef_q[31:16];
	assign samp  = (state_q == ST_MACR) ? frame[31:16] : frame[15:0];
	assign prod  = samp * cp;

	// volume scaling, full 32-bit signed product
	assign scl = $signed(accl_q[31:16]) * $signed(cfg.vol_l);
	assign scr = $signed(accr_q[31:16]) * $signed(cfg.vol_r);

	assign phase_n   = 32'd0 - job.phase;
	assign zero_frac = (job.phase[ROW_SHIFT +: ROW_INDEX_BITS] == '0)
		&& (job.phase[LERP_SHIFT +: 15] == '0);

	assign job_ready = (state_q == ST_IDLE) && !outv_q;
	assign busy      = (state_q != ST_IDLE) || outv_q;
	assign res_valid = outv_q;
	assign res_l     = outl_q;
	assign res_r     = outr_q;
	assign res_last  = outlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			outv_q    <= 1'b0;
			tap_q     <= '0;
			side_q    <= 1'b0;
			outlast_q <= 1'b0;
		end else begin
			if (outv_q && res_ready) outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready) begin
						ip_q   <= job.phase[ROW_SHIFT +: ROW_INDEX_BITS];
						lp_q   <= job.phase[LERP_SHIFT +: 15];
						in_q   <= zero_frac ? ROW_INDEX_BITS'(ROW_MAX)
							: phase_n[ROW_SHIFT +: ROW_INDEX_BITS];
						ln_q   <= zero_frac ? 15'h7fff : phase_n[LERP_SHIFT +: 15];
						last_q <= job.last;
						tap_q  <= '0;
						side_q <= 1'b0;
						accl_q <= '0;
						accr_q <= '0;
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					coef_q  <= coef_full;
					state_q <= ST_MACL;
				end
				ST_MACL: begin
					accl_q  <= accl_q + 32'(prod);
					state_q <= ST_MACR;
				end
				ST_MACR: begin
					accr_q <= accr_q + 32'(prod);
					side_q <= !side_q;
					if (side_q) tap_q <= tap_q + 1'b1;
					state_q <= (side_q && tap_q == TAP_W'(HALF_TAPS - 1)) ? ST_VOL : ST_COEF;
				end
				ST_VOL: begin
					if (!cfg.stereo) accr_q <= accl_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!outv_q) begin
						outl_q    <= {scl[30:0], 1'b0};
						outr_q    <= {scr[30:0], 1'b0};
						outlast_q <= last_q;
						outv_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |=> state_q == ST_COEF)
		else $error("job taken without starting");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && !res_ready) |=> outv_q && $stable(outl_q))
		else $error("result dropped while stalled");
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !outv_q)
		else $error("job taken over a pending result");
`endif

endmodule

// File: sv/polyphase_sinc_resampler.sv
// Top level of the 16-tap windowed-sinc polyphase resampler.
// A frame's first output follows acceptance through the front end's drain and issue
// states, then the back end's coefficient, left and right multiply states for every
// tap and side, and its volume and output states. A frame yields up to eight outputs.
// The next frame is taken once its predecessor's jobs are issued and the back end is empty.
// Reset (arst_n low, async): history and phase cleared, registers to defaults.
module polyphase_sinc_resampler #(
	parameter int HALF_TAPS       = psr_pkg::HALF_TAPS_DEF,
	parameter int PHASE_FRAC_BITS = psr_pkg::PHASE_FRAC_BITS_DEF,
	parameter int ROW_INDEX_BITS  = psr_pkg::ROW_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // sample_left, sample_right
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [63:0]                   m_axis_tdata,  // out_left, out_right
	output logic                          m_axis_tlast,  // last_of_run
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int HIST_DEPTH = 2 * HALF_TAPS;

	psr_pkg::cfg_t cfg_q;
	psr_pkg::job_t job;
	logic          job_valid, job_ready, back_busy;
	logic [31:0]   hist [HIST_DEPTH];
	logic [31:0]   res_l, res_r;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_inc <= psr_pkg::PHASE_INC_RST;
			cfg_q.down_tab  <= 1'b0;
			cfg_q.stereo    <= 1'b1;
			cfg_q.vol_l     <= psr_pkg::VOL_RST;
			cfg_q.vol_r     <= psr_pkg::VOL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psr_pkg::REG_PHASE_INC: cfg_q.phase_inc <= cfg_data;
				psr_pkg::REG_DOWN_TAB:  cfg_q.down_tab  <= cfg_data[0];
				psr_pkg::REG_STEREO:    cfg_q.stereo    <= cfg_data[0];
				psr_pkg::REG_VOL_L:     cfg_q.vol_l     <= cfg_data[15:0];
				psr_pkg::REG_VOL_R:     cfg_q.vol_r     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// history may only move once the back end has finished reading it
	psr_front #(.HIST_DEPTH(HIST_DEPTH), .PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_frame(s_axis_tdata),
		.phase_inc(cfg_q.phase_inc), .hist_free(!back_busy && !job_valid),
		.hist_q(hist), .job_valid, .job_ready, .job
	);

	psr_back #(.HALF_TAPS(HALF_TAPS), .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
		.ROW_INDEX_BITS(ROW_INDEX_BITS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .hist,
		.job_valid, .job_ready, .job, .busy(back_busy),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_l, .res_r, .res_last(m_axis_tlast)
	);

	assign m_axis_tdata = {res_r, res_l};

`ifndef NO_ASSERTIONS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid)
		else $error("frame taken while a result is pending");
	a_tlast_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tlast))
		else $error("tlast changed under stall");
	a_tdata_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("tdata changed under stall");
`endif

endmodule

// File: tb/psr_checker.sv
// Checker for the sinc resampler: own prediction of every output frame, compared in order.
module psr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          fails,
	output int          pending
);

	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} frame_out_t;

	frame_out_t     want_q[$];
	logic [31:0]    hist[16];
	logic [31:0]    phase;
	psr_pkg::cfg_t  regs;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h want %h", what, got, exp);
		fails++;
	endtask

	function automatic int hi16(input int v);
		return v >>> 16;
	endfunction

	function automatic int coef(input int unsigned idx);
		if (idx >= psr_pkg::ROM_SIZE)
			return 0;
		return regs.down_tab ? int'(psr_pkg::ROM_DOWN[idx]) : int'(psr_pkg::ROM_UP[idx]);
	endfunction

	// Coefficient linearly interpolated between a row and the next.
	function automatic int interp(input int unsigned idx, input int weight);
		int c0;
		int d;
		c0 = coef(idx);
		d = (coef(idx + 1) - c0) << 1;
		return c0 + weight * hi16(d);
	endfunction

	function automatic void convolve(output int acc_l, output int acc_r);
		logic [31:0] nph;
		int unsigned row_p;
		int unsigned row_n;
		int w_p;
		int w_n;
		int cp;
		int cn;
		int r;
		logic [31:0] fp;
		logic [31:0] fn;
		nph = 32'd0 - phase;
		row_p = phase[29:26];
		w_p = phase[25:11];
		row_n = nph[29:26];
		w_n = nph[25:11];
		acc_l = 0;
		r = 0;
		// zero fraction: negative side takes the top row and full weight
		if (row_p == 0 && w_p == 0) begin
			row_n = 15;
			w_n = 16'h7fff;
		end
		for (int i = 0; i < 8; i++) begin
			cp = hi16(interp((i << 4) + row_p, w_p));
			cn = hi16(interp((i << 4) + row_n, w_n));
			fp = hist[7 - i];
			fn = hist[8 + i];
			acc_l += int'(signed'(fp[15:0])) * cp;
			acc_l += int'(signed'(fn[15:0])) * cn;
			r += int'(signed'(fp[31:16])) * cp;
			r += int'(signed'(fn[31:16])) * cn;
		end
		acc_r = regs.stereo ? r : acc_l;
	endfunction

	task automatic take_frame(input logic [31:0] sample);
		frame_out_t f;
		int l;
		int r;
		int n;
		for (int i = 0; i < 15; i++)
			hist[i] = hist[i + 1];
		hist[15] = sample;
		if (phase[31:30] != 0)
			phase -= 32'h4000_0000;
		n = 0;
		while (phase[31:30] == 0 && n < psr_pkg::MAX_RESULTS) begin
			convolve(l, r);
			f.left = (hi16(l) * int'(signed'(regs.vol_l))) * 2;
			f.right = (hi16(r) * int'(signed'(regs.vol_r))) * 2;
			f.last = 1'b0;
			want_q.push_back(f);
			phase += regs.phase_inc;
			n++;
		end
		if (n > 0)
			want_q[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_out_t w;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				hist[i] = '0;
			phase = '0;
			regs = '{psr_pkg::PHASE_INC_RST, 1'b0, 1'b1, psr_pkg::VOL_RST, psr_pkg::VOL_RST};
			want_q.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				psr_pkg::REG_PHASE_INC: regs.phase_inc = cfg_data;
				psr_pkg::REG_DOWN_TAB:  regs.down_tab = cfg_data[0];
				psr_pkg::REG_STEREO:    regs.stereo = cfg_data[0];
				psr_pkg::REG_VOL_L:     regs.vol_l = cfg_data[15:0];
				psr_pkg::REG_VOL_R:     regs.vol_r = cfg_data[15:0];
				default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (want_q.size() == 0) begin
					report("unexpected item", m_axis_tdata[31:0], '0);
				end else begin
					w = want_q.pop_front();
					if (m_axis_tdata[31:0] !== w.left)
						report("out_left", m_axis_tdata[31:0], w.left);
					if (m_axis_tdata[63:32] !== w.right)
						report("out_right", m_axis_tdata[63:32], w.right);
					if (m_axis_tlast !== w.last)
						report("last_of_run", 32'(m_axis_tlast), 32'(w.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_frame(s_axis_tdata);
		end
		pending = want_q.size();
	end

endmodule

// File: tb/testbench.sv
// Top of the resampler testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;

	localparam int LIMIT = 4_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // sample_left, sample_right
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // out_left, out_right
	logic        m_axis_tlast;   // last_of_run
	logic        cfg_valid;
	logic        cfg_ready;
	logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [psr_pkg::CFG_DATA_W-1:0] cfg_data;
	int          fails;
	int          pending;
	int          cycles;
	int          burst_left;

	polyphase_sinc_resampler dut (.*);

	psr_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run-away guard; far above the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver stall pattern, in three rotating modes:
	// always ready, coin flip, or long stalls on a slow cycle.
	always @(posedge clk) begin
		case ((cycles / 700) % 3)
		0: m_axis_tready <= 1'b1;
		1: m_axis_tready <= $urandom_range(0, 1);
		default: m_axis_tready <= (cycles % 37) > 25;
		endcase
	end

	// One item onto the stream; valid stays high across back-to-back items.
	// Ready is sampled at the falling edge, where it holds its value for the next rise.
	task automatic send(input logic [15:0] left, input logic [15:0] right);
		logic rdy;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// Waits until every predicted item is out, then lets the last silent frames drain.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	// Valid is left high for a following write; setup drops it after the last one.
	task automatic write_reg(input logic [psr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic setup(input logic [31:0] inc, input logic down, input logic stereo,
			input logic [15:0] vl, input logic [15:0] vr);
		write_reg(psr_pkg::REG_PHASE_INC, inc);
		write_reg(psr_pkg::REG_DOWN_TAB, {31'b0, down});
		write_reg(psr_pkg::REG_STEREO, {31'b0, stereo});
		write_reg(psr_pkg::REG_VOL_L, {16'b0, vl});
		write_reg(psr_pkg::REG_VOL_R, {16'b0, vr});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly full-range noise, sometimes a rail or zero.
	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'h0000;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_inc();
		case ($urandom_range(0, 5))
		0: return 32'h0800_0000;
		1: return 32'h8000_0000;
		2: return 32'h4000_0000;
		default: return $urandom_range(32'h0800_0000, 32'h8000_0000);
		endcase
	endfunction

	function automatic logic [15:0] rand_vol();
		case ($urandom_range(0, 5))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'd4096;
		default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: zero phase fraction on every output, stereo, upsampling table.
		send(16'h7fff, 16'h8000);
		send(16'h8000, 16'h7fff);
		send(16'h7fff, 16'h7fff);
		send(16'h8000, 16'h8000);
		send(16'h0000, 16'hffff);
		send(16'hffff, 16'h0000);
		drain();

		// Smallest increment: capped at eight outputs per item; mono, downsampling
		// table, full-scale volumes to force wrap.
		setup(32'h0800_0000, 1'b1, 1'b0, 16'h8000, 16'h7fff);
		repeat (5) send(16'h8000, 16'h7fff);
		send(16'h7fff, 16'h1234);
		drain();

		// Largest increment: phase reaches two, silent items in between.
		setup(32'h8000_0000, 1'b0, 1'b1, 16'h7fff, 16'h8000);
		repeat (6) send(16'h7fff, 16'h8000);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 10; p++) begin
			setup(rand_inc(), $urandom_range(0, 1), $urandom_range(0, 1),
				rand_vol(), rand_vol());
			repeat (50) send(rand_sample(), rand_sample());
			drain();
		end

		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
